### rtl/core/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types and constants of the stream-bypass RRIP replacement unit.
// ----------------------------------------------------------------------------
package srb_pkg;

    localparam int SET_W     = 11;
    localparam int WAY_W     = 4;
    localparam int PC_W      = 8;
    localparam int ADDR_W    = 48;
    localparam int STRIDE_W  = 49;
    localparam int SIG_W     = 6;
    localparam int SIG_ENTRIES = 64;
    localparam int AGE_W     = 2;
    localparam int CNT_W     = 2;
    localparam int CFG_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int LFSR_W    = 16;

    localparam logic [AGE_W-1:0]  AGE_NEAR = 2'd0;
    localparam logic [AGE_W-1:0]  AGE_LONG = 2'd2;
    localparam logic [AGE_W-1:0]  AGE_MAX  = 2'd3;
    localparam logic [CNT_W-1:0]  CNT_MAX  = 2'd3;
    localparam logic [CNT_W-1:0]  CNT_INIT = 2'd1;
    localparam logic [CFG_W-1:0]  THR_INIT = 2'd2;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STREAM_THR = 1'b0,
        CFG_HOT_THR    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic clr;
        logic accept;
        logic modr;
        logic vex;
        logic ux1;
        logic ux2;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic set_ok;
        logic is_victim;
        logic out_free;
    } t_sts;

endpackage

### rtl/core/srb_if.sv
// ----------------------------------------------------------------------------
// srb_req_if / srb_rsp_if
// Valid/ready channels carrying request words and victim words.
// ----------------------------------------------------------------------------
interface srb_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [srb_pkg::SET_W-1:0]    set_index;
    logic [srb_pkg::WAY_W-1:0]    way_index;
    logic [srb_pkg::PC_W-1:0]     pc_low;
    logic [srb_pkg::ADDR_W-1:0]   paddr;
    logic                         hit;
    modport source (output valid, req_type, set_index, way_index, pc_low, paddr, hit,
                    input ready);
    modport sink (input valid, req_type, set_index, way_index, pc_low, paddr, hit,
                  output ready);
endinterface

interface srb_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [srb_pkg::WAY_W-1:0]    victim_way;
    modport source (output valid, victim_way, input ready);
    modport sink (input valid, victim_way, output ready);
endinterface

### rtl/core/srb_ctrl.sv
// ----------------------------------------------------------------------------
// srb_ctrl
// Sequencer: clearing pass, set reduction, metadata read and the
// victim or update steps.
// ----------------------------------------------------------------------------
module srb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  srb_pkg::t_sts  i_sts,
    output srb_pkg::t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_MOD  = 7'b0000100,
        S_RD   = 7'b0001000,
        S_VEX  = 7'b0010000,
        S_UX1  = 7'b0100000,
        S_UX2  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.modr = 1'b1;
                if (i_sts.set_ok) n_state = S_RD;
            end
            S_RD: begin
                n_state = i_sts.is_victim ? S_VEX : S_UX1;
            end
            S_VEX: begin
                if (i_sts.out_free) begin
                    o_cmd.vex = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_UX1: begin
                o_cmd.ux1 = 1'b1;
                n_state   = S_UX2;
            end
            S_UX2: begin
                o_cmd.ux2 = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLR;
        else          r_state <= n_state;
    end

endmodule

### rtl/core/srb_dpath.sv
// ----------------------------------------------------------------------------
// srb_dpath
// Set metadata memories, stride tracking, signature training, aging and
// the victim output register.
// ----------------------------------------------------------------------------
module srb_dpath #(
    parameter int NUM_SETS     = 2048,
    parameter int NUM_WAYS     = 16,
    parameter int LEADER_COUNT = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srb_pkg::t_cmd                 i_cmd,
    output srb_pkg::t_sts                 o_sts,
    input  logic                          i_cfg_we,
    input  logic [srb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [srb_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_req_type,
    input  logic [srb_pkg::SET_W-1:0]     i_set_index,
    input  logic [srb_pkg::WAY_W-1:0]     i_way_index,
    input  logic [srb_pkg::PC_W-1:0]      i_pc_low,
    input  logic [srb_pkg::ADDR_W-1:0]    i_paddr,
    input  logic                          i_hit,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [srb_pkg::WAY_W-1:0]     o_victim_way
);

    localparam int AW        = $clog2(NUM_SETS);
    localparam int LEAD_BASE = NUM_SETS - LEADER_COUNT;
    localparam int ROW_W     = srb_pkg::ADDR_W + srb_pkg::STRIDE_W + srb_pkg::CNT_W;

    typedef logic [NUM_WAYS-1:0][srb_pkg::AGE_W-1:0] t_age_row;
    typedef logic [NUM_WAYS-1:0][srb_pkg::SIG_W-1:0] t_sig_row;

    t_age_row                      mem_age [NUM_SETS];
    t_sig_row                      mem_sig [NUM_SETS];
    logic [ROW_W-1:0]              mem_str [NUM_SETS];
    logic [srb_pkg::CNT_W-1:0]     mem_sc  [srb_pkg::SIG_ENTRIES];

    logic                          r_type, r_hit;
    logic [srb_pkg::SET_W-1:0]     r_set;
    logic [srb_pkg::WAY_W-1:0]     r_way;
    logic [srb_pkg::PC_W-1:0]      r_pc;
    logic [srb_pkg::ADDR_W-1:0]    r_paddr;
    logic [AW-1:0]                 r_clr;
    logic [srb_pkg::CFG_W-1:0]     r_stream_thr, r_hot_thr;
    logic [srb_pkg::LFSR_W-1:0]    r_lfsr;
    t_age_row                      r_age_rd;
    t_sig_row                      r_sig_rd;
    logic [ROW_W-1:0]              r_str_rd;
    logic [srb_pkg::CNT_W-1:0]     r_cnt, r_sc_old, r_sc_new;
    logic [srb_pkg::SIG_W-1:0]     r_old_sig;
    logic                          r_out_valid;
    logic [srb_pkg::WAY_W-1:0]     r_out_way;

    logic [AW-1:0]                 rd_addr;
    logic [srb_pkg::SIG_W-1:0]     sig, old_sig;
    logic                          way_ok, brrip;
    logic                          any3, any2, any1;
    logic [srb_pkg::AGE_W-1:0]     lift;
    t_age_row                      aged_row, upd_row;
    t_sig_row                      new_sig_row;
    logic [srb_pkg::WAY_W-1:0]     first3;
    logic [srb_pkg::ADDR_W-1:0]    prev_addr;
    logic [srb_pkg::STRIDE_W-1:0]  prev_stride, stride;
    logic [srb_pkg::CNT_W-1:0]     prev_cnt, cnt_next;
    logic                          same;
    logic [srb_pkg::CNT_W-1:0]     sc_dec, sc_inc, sc_sig;
    logic                          hot, streaming, step_lfsr;
    logic [srb_pkg::LFSR_W-1:0]    lfsr_next;
    logic [srb_pkg::AGE_W-1:0]     ins_age;

    assign rd_addr = AW'(r_set);
    assign sig     = r_pc[7:2] ^ r_set[5:0];
    assign way_ok  = 32'(r_way) < NUM_WAYS;
    assign brrip   = (LEAD_BASE >= 0) && (32'(r_set) >= LEAD_BASE);

    assign o_sts.clr_last  = (32'(r_clr) == NUM_SETS - 1);
    assign o_sts.set_ok    = (32'(r_set) < NUM_SETS);
    assign o_sts.is_victim = !r_type;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            any3 = any3 | (r_age_rd[w] == 2'd3);
            any2 = any2 | (r_age_rd[w] == 2'd2);
            any1 = any1 | (r_age_rd[w] == 2'd1);
        end
        lift = any3 ? 2'd0 : any2 ? 2'd1 : any1 ? 2'd2 : 2'd3;
        first3 = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            aged_row[w] = r_age_rd[w] + lift;
            if (aged_row[w] == srb_pkg::AGE_MAX) first3 = srb_pkg::WAY_W'(w);
        end
    end

    always_comb begin
        old_sig = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (32'(r_way) == w) old_sig = r_sig_rd[w];
        end
    end

    always_comb begin
        {prev_addr, prev_stride, prev_cnt} = r_str_rd;
        stride = (prev_addr != '0) ? ({1'b0, r_paddr} - {1'b0, prev_addr}) : '0;
        same   = (prev_addr != '0) && (stride == prev_stride) && (stride != '0);
        if (same) cnt_next = (prev_cnt == srb_pkg::CNT_MAX) ? prev_cnt : prev_cnt + 2'd1;
        else      cnt_next = (prev_cnt == '0) ? prev_cnt : prev_cnt - 2'd1;
    end

    always_comb begin
        sc_inc    = (r_sc_old == srb_pkg::CNT_MAX) ? r_sc_old : r_sc_old + 2'd1;
        sc_dec    = (r_sc_old == '0) ? r_sc_old : r_sc_old - 2'd1;
        sc_sig    = (sig == r_old_sig) ? sc_dec : r_sc_new;
        hot       = sc_sig >= r_hot_thr;
        streaming = r_cnt >= r_stream_thr;
        step_lfsr = !r_hit && way_ok && !hot && !streaming && brrip;
        lfsr_next = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[15:1]};
        if (streaming && !hot) ins_age = srb_pkg::AGE_MAX;
        else if (hot)          ins_age = srb_pkg::AGE_NEAR;
        else if (brrip)        ins_age = (lfsr_next[4:0] == '0) ? srb_pkg::AGE_NEAR
                                                                : srb_pkg::AGE_LONG;
        else                   ins_age = srb_pkg::AGE_LONG;
        upd_row     = r_age_rd;
        new_sig_row = r_sig_rd;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (32'(r_way) == w) begin
                upd_row[w]     = r_hit ? srb_pkg::AGE_NEAR : ins_age;
                new_sig_row[w] = sig;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr)                 mem_age[r_clr] <= {NUM_WAYS{srb_pkg::AGE_LONG}};
        else if (i_cmd.vex)            mem_age[rd_addr] <= aged_row;
        else if (i_cmd.ux2 && way_ok)  mem_age[rd_addr] <= upd_row;
        r_age_rd <= mem_age[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr)                         mem_sig[r_clr] <= '0;
        else if (i_cmd.ux2 && way_ok && !r_hit) mem_sig[rd_addr] <= new_sig_row;
        r_sig_rd <= mem_sig[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr)      mem_str[r_clr] <= '0;
        else if (i_cmd.ux1) mem_str[rd_addr] <= {r_paddr, stride, cnt_next};
        r_str_rd <= mem_str[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr)                mem_sc[r_clr[srb_pkg::SIG_W-1:0]] <= srb_pkg::CNT_INIT;
        else if (i_cmd.ux2 && way_ok) mem_sc[r_old_sig] <= r_hit ? sc_inc : sc_dec;
        r_sc_old <= mem_sc[old_sig];
        r_sc_new <= mem_sc[sig];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_type  <= i_req_type;
            r_set   <= i_set_index;
            r_way   <= i_way_index;
            r_pc    <= i_pc_low;
            r_paddr <= i_paddr;
            r_hit   <= i_hit;
        end else if (i_cmd.modr && !o_sts.set_ok) begin
            r_set <= r_set - srb_pkg::SET_W'(NUM_SETS);
        end
        if (i_cmd.ux1) begin
            r_cnt     <= cnt_next;
            r_old_sig <= old_sig;
        end
        if (i_cmd.vex) r_out_way <= first3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr        <= '0;
            r_stream_thr <= srb_pkg::THR_INIT;
            r_hot_thr    <= srb_pkg::THR_INIT;
            r_lfsr       <= srb_pkg::LFSR_SEED;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + AW'(1);
            if (i_cfg_we) begin
                unique case (srb_pkg::t_cfg_idx'(i_cfg_idx))
                    srb_pkg::CFG_STREAM_THR: r_stream_thr <= i_cfg_data;
                    srb_pkg::CFG_HOT_THR:    r_hot_thr    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.ux2 && step_lfsr) r_lfsr <= lfsr_next;
            if (i_cmd.vex)        r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_victim_way = r_out_way;

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clr, i_cmd.accept, i_cmd.modr, i_cmd.vex, i_cmd.ux1, i_cmd.ux2}))
        else $error("more than one datapath command at once");
    a_vex_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.vex |=> r_out_valid)
        else $error("victim step did not load the output register");
    a_set_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.vex || i_cmd.ux1 || i_cmd.ux2) |-> o_sts.set_ok)
        else $error("set index not reduced before metadata access");
    a_ux_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ux1 |=> i_cmd.ux2)
        else $error("update steps out of order");

endmodule

### rtl/core/ship_rrip_stream_bypass_replacement_unit.sv
// ----------------------------------------------------------------------------
// ship_rrip_stream_bypass_replacement_unit
// SRRIP victim selection with signature training and stream bypass.
// ----------------------------------------------------------------------------
// After reset a clearing pass over all NUM_SETS sets initializes the set
// metadata and accepts no word. One word is then handled at a time: the
// set index is reduced by NUM_SETS until in range, the per-set metadata
// memories are read into registers, then a victim request takes its victim
// step and an update request its stride step and then its age and signature
// step, which uses the dependent read of the signature counters. A victim
// word may wait in the output register while the next request is accepted.
module ship_rrip_stream_bypass_replacement_unit #(
    parameter int NUM_SETS     = 2048,
    parameter int NUM_WAYS     = 16,
    parameter int LEADER_COUNT = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [srb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [srb_pkg::CFG_W-1:0]     i_cfg_data,
    srb_req_if.sink                       i_req,
    srb_rsp_if.source                     o_rsp
);

    srb_pkg::t_cmd cmd;
    srb_pkg::t_sts sts;

    srb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    srb_dpath #(
        .NUM_SETS     (NUM_SETS),
        .NUM_WAYS     (NUM_WAYS),
        .LEADER_COUNT (LEADER_COUNT)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req_type   (i_req.req_type),
        .i_set_index  (i_req.set_index),
        .i_way_index  (i_req.way_index),
        .i_pc_low     (i_req.pc_low),
        .i_paddr      (i_req.paddr),
        .i_hit        (i_req.hit),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_victim_way (o_rsp.victim_way)
    );

endmodule

### tb/srb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_checker
// Watches the request, victim and register ports of the replacement unit,
// keeps its own copy of the ages, signatures, counters and stride state,
// predicts each victim word and compares it with the word the unit returns.
// ----------------------------------------------------------------------------
module srb_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [srb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [srb_pkg::CFG_W-1:0]     i_cfg_data,
    srb_req_if                            i_req,
    srb_rsp_if                            i_rsp,
    output int                            o_errors,
    output int                            o_pending
);

    localparam int NSETS  = 2048;
    localparam int NWAYS  = 16;
    localparam int LEADER = 32;

    logic [srb_pkg::AGE_W-1:0]    age_mem [0:NSETS*NWAYS-1];
    logic [srb_pkg::SIG_W-1:0]    blk_sig [0:NSETS*NWAYS-1];
    logic [srb_pkg::CNT_W-1:0]    sig_cnt [0:srb_pkg::SIG_ENTRIES-1];
    logic [srb_pkg::ADDR_W-1:0]   prev_addr_mem [0:NSETS-1];
    logic [srb_pkg::STRIDE_W-1:0] prev_stride_mem [0:NSETS-1];
    logic [srb_pkg::CNT_W-1:0]    run_cnt [0:NSETS-1];
    logic [srb_pkg::LFSR_W-1:0]   lfsr;
    logic [srb_pkg::CFG_W-1:0]    stream_thr;
    logic [srb_pkg::CFG_W-1:0]    hot_thr;
    logic [srb_pkg::WAY_W-1:0]    victim_q [$];

    always @(posedge i_clk) begin
        int base;
        int slot;
        logic [srb_pkg::AGE_W-1:0] top;
        logic [srb_pkg::AGE_W-1:0] lift;
        logic [srb_pkg::WAY_W-1:0] pick;
        logic found;
        logic [srb_pkg::STRIDE_W-1:0] stride;
        logic [srb_pkg::SIG_W-1:0] sig;
        logic [srb_pkg::SIG_W-1:0] old;
        logic streaming;
        logic hot;
        logic fb;
        if (!i_rst_n) begin
            for (int i = 0; i < NSETS*NWAYS; i++) begin
                age_mem[i] = srb_pkg::AGE_LONG;
                blk_sig[i] = '0;
            end
            for (int i = 0; i < srb_pkg::SIG_ENTRIES; i++) sig_cnt[i] = srb_pkg::CNT_INIT;
            for (int i = 0; i < NSETS; i++) begin
                prev_addr_mem[i] = '0;
                prev_stride_mem[i] = '0;
                run_cnt[i] = '0;
            end
            lfsr = srb_pkg::LFSR_SEED;
            stream_thr = srb_pkg::THR_INIT;
            hot_thr = srb_pkg::THR_INIT;
            victim_q.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == srb_pkg::CFG_STREAM_THR) stream_thr = i_cfg_data;
                else if (i_cfg_idx == srb_pkg::CFG_HOT_THR) hot_thr = i_cfg_data;
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (victim_q.size() == 0) begin
                    $display("%0t: unexpected victim word, actual %0d", $time,
                             i_rsp.victim_way);
                    o_errors <= o_errors + 1;
                end else begin
                    pick = victim_q.pop_front();
                    if (pick !== i_rsp.victim_way) begin
                        $display("%0t: victim_way mismatch, expected %0d, actual %0d",
                                 $time, pick, i_rsp.victim_way);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                base = int'(i_req.set_index) * NWAYS;
                if (i_req.req_type == 1'b0) begin
                    top = '0;
                    for (int w = 0; w < NWAYS; w++)
                        if (age_mem[base+w] > top) top = age_mem[base+w];
                    lift = srb_pkg::AGE_MAX - top;
                    pick = '0;
                    found = 1'b0;
                    for (int w = 0; w < NWAYS; w++) begin
                        age_mem[base+w] = age_mem[base+w] + lift;
                        if (!found && age_mem[base+w] == srb_pkg::AGE_MAX) begin
                            pick = srb_pkg::WAY_W'(w);
                            found = 1'b1;
                        end
                    end
                    victim_q.push_back(pick);
                end else begin
                    stride = '0;
                    if (prev_addr_mem[i_req.set_index] != '0)
                        stride = {1'b0, i_req.paddr} - {1'b0, prev_addr_mem[i_req.set_index]};
                    if (prev_addr_mem[i_req.set_index] != '0 && stride != '0 &&
                        stride == prev_stride_mem[i_req.set_index]) begin
                        if (run_cnt[i_req.set_index] < srb_pkg::CNT_MAX)
                            run_cnt[i_req.set_index]++;
                    end else if (run_cnt[i_req.set_index] > 0) begin
                        run_cnt[i_req.set_index]--;
                    end
                    prev_addr_mem[i_req.set_index] = i_req.paddr;
                    prev_stride_mem[i_req.set_index] = stride;
                    slot = base + int'(i_req.way_index);
                    sig = i_req.pc_low[7:2] ^ i_req.set_index[5:0];
                    old = blk_sig[slot];
                    if (i_req.hit) begin
                        age_mem[slot] = srb_pkg::AGE_NEAR;
                        if (sig_cnt[old] < srb_pkg::CNT_MAX) sig_cnt[old]++;
                    end else begin
                        if (sig_cnt[old] > 0) sig_cnt[old]--;
                        blk_sig[slot] = sig;
                        streaming = run_cnt[i_req.set_index] >= stream_thr;
                        hot = sig_cnt[sig] >= hot_thr;
                        if (streaming && !hot) begin
                            age_mem[slot] = srb_pkg::AGE_MAX;
                        end else if (hot) begin
                            age_mem[slot] = srb_pkg::AGE_NEAR;
                        end else if (int'(i_req.set_index) >= NSETS - LEADER) begin
                            fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
                            lfsr = {fb, lfsr[15:1]};
                            age_mem[slot] = (lfsr[4:0] == 5'd0) ? srb_pkg::AGE_NEAR
                                                                : srb_pkg::AGE_LONG;
                        end else begin
                            age_mem[slot] = srb_pkg::AGE_LONG;
                        end
                    end
                end
            end
            o_pending <= victim_q.size();
        end
    end
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random request words into the replacement unit with
// random gaps and back-pressure, steps the threshold registers through
// several settings, and judges by the checker's error and pending counts.
// ----------------------------------------------------------------------------
module tb_top;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [srb_pkg::CFG_IDX_W-1:0] i_cfg_idx = srb_pkg::CFG_STREAM_THR;
    logic [srb_pkg::CFG_W-1:0]     i_cfg_data = '0;
    int                            errors;
    int                            pending;
    int                            sent_cnt = 0;
    bit                            long_hold_done = 1'b0;

    srb_req_if req ();
    srb_rsp_if rsp ();

    ship_rrip_stream_bypass_replacement_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req),
        .o_rsp      (rsp)
    );

    srb_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req),
        .i_rsp      (rsp),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        req.valid = 1'b0;
        req.req_type = 1'b0;
        req.set_index = '0;
        req.way_index = '0;
        req.pc_low = '0;
        req.paddr = '0;
        req.hit = 1'b0;
        rsp.ready = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // The receiver stalls at random and once holds off for a long stretch.
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(99);
        if (!long_hold_done && sent_cnt > 500) begin
            long_hold_done = 1'b1;
            rsp.ready <= 1'b0;
            repeat (400) @(posedge i_clk);
        end else if (r < 8) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(30, 8)) @(posedge i_clk);
        end else begin
            rsp.ready <= (r < 70) || (sent_cnt % 200 < 60);
        end
    end

    task automatic send_word(input logic rt, input logic [srb_pkg::SET_W-1:0] s,
                             input logic [srb_pkg::WAY_W-1:0] w,
                             input logic [srb_pkg::PC_W-1:0] pc,
                             input logic [srb_pkg::ADDR_W-1:0] a, input logic h);
        req.valid <= 1'b1;
        req.req_type <= rt;
        req.set_index <= s;
        req.way_index <= w;
        req.pc_low <= pc;
        req.paddr <= a;
        req.hit <= h;
        @(negedge i_clk);
        while (!req.ready) @(negedge i_clk);
        @(posedge i_clk);
        sent_cnt++;
    endtask

    task automatic idle_gap();
        int r;
        r = $urandom_range(99);
        if (r >= 70 || (sent_cnt / 150) % 2 == 1) begin
            if (r >= 70) begin
                req.valid <= 1'b0;
                if (r < 95) repeat ($urandom_range(3, 1)) @(posedge i_clk);
                else repeat ($urandom_range(40, 10)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_and_write(input logic [srb_pkg::CFG_W-1:0] st,
                                   input logic [srb_pkg::CFG_W-1:0] ht);
        req.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= srb_pkg::CFG_STREAM_THR;
        i_cfg_data <= st;
        @(posedge i_clk);
        i_cfg_idx <= srb_pkg::CFG_HOT_THR;
        i_cfg_data <= ht;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [srb_pkg::ADDR_W-1:0] prev_addr [int];
        logic [srb_pkg::ADDR_W-1:0] step_of [int];
        int set_pool [8];
        logic [srb_pkg::PC_W-1:0] pc_pool [6];
        logic [srb_pkg::CFG_W-1:0] st_list [5];
        logic [srb_pkg::CFG_W-1:0] ht_list [5];
        int s;
        int r;
        logic [srb_pkg::ADDR_W-1:0] a;
        logic [srb_pkg::PC_W-1:0] pc;
        set_pool = '{0, 5, 31, 32, 1000, 2015, 2016, 2047};
        st_list = '{2'd1, 2'd0, 2'd3, 2'd3, 2'd1};
        ht_list = '{2'd1, 2'd0, 2'd3, 2'd0, 2'd2};
        for (int i = 0; i < 6; i++) pc_pool[i] = srb_pkg::PC_W'($urandom);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(1'b0, 11'd0, 4'd0, 8'd0, 48'd0, 1'b0);
        send_word(1'b0, 11'd2047, 4'd0, 8'd0, 48'd0, 1'b0);
        send_word(1'b1, 11'd2047, 4'd15, 8'd255, {srb_pkg::ADDR_W{1'b1}}, 1'b0);
        send_word(1'b1, 11'd2047, 4'd15, 8'd255, 48'd0, 1'b1);
        send_word(1'b1, 11'd0, 4'd0, 8'd0, 48'd0, 1'b1);
        send_word(1'b1, 11'd31, 4'd3, 8'hAA, 48'h1234, 1'b0);
        send_word(1'b1, 11'd2016, 4'd7, 8'h55, 48'h8000, 1'b0);
        send_word(1'b1, 11'd2015, 4'd8, 8'h0F, 48'h4000, 1'b0);
        for (int i = 0; i < 5; i++)
            send_word(1'b1, 11'd5, srb_pkg::WAY_W'(i), 8'h40,
                      48'h1000 + 48'h40 * srb_pkg::ADDR_W'(i), 1'b0);
        send_word(1'b1, 11'd5, 4'd9, 8'h40, 48'h1000, 1'b0);
        send_word(1'b1, 11'd5, 4'd1, 8'h40, 48'h1000, 1'b1);
        send_word(1'b0, 11'd5, 4'd0, 8'd0, 48'd0, 1'b0);
        send_word(1'b0, 11'd2016, 4'd0, 8'd0, 48'd0, 1'b0);
        send_word(1'b0, 11'd2047, 4'd0, 8'd0, 48'd0, 1'b0);
        send_word(1'b0, 11'd31, 4'd0, 8'd0, 48'd0, 1'b0);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) drain_and_write(st_list[ph-1], ht_list[ph-1]);
            for (int n = 0; n < 255; n++) begin
                r = $urandom_range(99);
                s = (r < 85) ? set_pool[$urandom_range(7)] : $urandom_range(2047);
                if (!prev_addr.exists(s)) begin
                    prev_addr[s] = srb_pkg::ADDR_W'({$urandom, $urandom});
                    step_of[s] = 48'h40;
                end
                if ($urandom_range(19) == 0) begin
                    case ($urandom_range(3))
                        0: step_of[s] = 48'h40;
                        1: step_of[s] = -48'h40;
                        2: step_of[s] = 48'h1000;
                        default: step_of[s] = srb_pkg::ADDR_W'({$urandom, $urandom});
                    endcase
                end
                r = $urandom_range(99);
                if (r < 70) a = prev_addr[s] + step_of[s];
                else if (r < 80) a = srb_pkg::ADDR_W'({$urandom, $urandom});
                else if (r < 85) a = '0;
                else if (r < 90) a = {srb_pkg::ADDR_W{1'b1}};
                else a = prev_addr[s];
                prev_addr[s] = a;
                pc = ($urandom_range(3) != 0) ? pc_pool[$urandom_range(5)]
                                              : srb_pkg::PC_W'($urandom);
                send_word($urandom_range(99) >= 35, srb_pkg::SET_W'(s),
                          srb_pkg::WAY_W'($urandom), pc, a, 1'($urandom));
                idle_gap();
            end
        end

        req.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (30) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

### sim.f
rtl/core/srb_pkg.sv
rtl/core/srb_if.sv
rtl/core/srb_ctrl.sv
rtl/core/srb_dpath.sv
rtl/core/ship_rrip_stream_bypass_replacement_unit.sv
tb/srb_checker.sv
tb/tb_top.sv
